>>> src/conv5_pkg.sv
// Shared types and constants for the 5x5 valid-window convolution core.
// No dependencies; imported by every module of the block.
`default_nettype none

package conv5_pkg;

	localparam int KSIZE          = 5;
	localparam int WIN_EDGE       = KSIZE - 1;   // first row/col with a full window
	localparam int PIX_BITS       = 8;
	localparam int LINE_BITS      = PIX_BITS * (KSIZE - 1);
	localparam int FIELD_BITS     = 12;
	localparam int ROW_BITS       = FIELD_BITS * KSIZE;
	localparam int CFG_DATA_BITS  = ROW_BITS;
	localparam int FRAC_BITS      = 4;
	localparam int MAX_FRAC       = 12;
	localparam int BIAS_BITS      = 9;
	localparam int IW_BITS        = 11;
	localparam int MIN_WIDTH      = 5;
	localparam int RESET_WIDTH    = 1024;
	localparam int PIX_MAX        = 255;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;
	localparam int DEF_COEF_BITS  = 12;

	typedef enum logic [2:0] {
		REG_KROW0,
		REG_KROW1,
		REG_KROW2,
		REG_KROW3,
		REG_KROW4,
		REG_FRAC,
		REG_BIAS,
		REG_WIDTH
	} cfg_reg_t;

	typedef logic [KSIZE-1:0][ROW_BITS-1:0] kernel_t;

	typedef struct packed {
		kernel_t                      kernel;
		logic [FRAC_BITS-1:0]         frac;
		logic signed [BIAS_BITS-1:0]  bias;
	} filt_cfg_t;

	// [row][col][bit], col 0 is the leftmost (oldest) column
	typedef logic [KSIZE-1:0][KSIZE-1:0][PIX_BITS-1:0] window_t;

endpackage

`default_nettype wire

>>> src/conv5_line.sv
// Line store: one word per column holding the four previous rows of that column.
// Registered read with write-to-read bypass; uses conv5_pkg.
`default_nettype none

module conv5_line
	import conv5_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_WIDTH
) (
	input  wire logic                      clk,
	input  wire logic                      rd_en,
	input  wire logic [$clog2(DEPTH)-1:0]  rd_addr,
	output logic [LINE_BITS-1:0]           rd_data,
	input  wire logic                      wr_en,
	input  wire logic [$clog2(DEPTH)-1:0]  wr_addr,
	input  wire logic [LINE_BITS-1:0]      wr_data
);

	logic [LINE_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// the word still being written this edge is newer than the array copy
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_addr == rd_addr)) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

endmodule

`default_nettype wire

>>> src/conv5_mac.sv
// Multiply-accumulate pipeline: 25 products, row sums, then round, bias, saturate.
// Three elastic stages, the last one is the output register; uses conv5_pkg.
`default_nettype none

module conv5_mac
	import conv5_pkg::*;
#(
	parameter int COEF_BITS = DEF_COEF_BITS,
	parameter int RW        = 12,
	parameter int XW        = 10
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire filt_cfg_t         cfg,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire window_t           win,
	input  wire logic [RW-1:0]     in_row,
	input  wire logic [XW-1:0]     in_col,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [PIX_BITS-1:0]    pixel_out,
	output logic [RW-1:0]          out_row,
	output logic [XW-1:0]          out_col
);

	localparam int PW  = COEF_BITS + PIX_BITS + 1;   // one product
	localparam int RSW = PW + 3;                     // sum of five
	localparam int SW  = RSW + 3;                    // sum of twenty-five
	localparam int TW  = SW + 2;

	logic signed [PW-1:0]  prod_s1 [KSIZE][KSIZE];
	logic signed [RSW-1:0] rsum_s2 [KSIZE];
	logic [RW-1:0]         row_s1, row_s2;
	logic [XW-1:0]         col_s1, col_s2;
	logic                  valid_s1, valid_s2;
	logic                  ready_s1, ready_s2, ready_out;

	logic signed [PW-1:0]  prod_d [KSIZE][KSIZE];
	logic signed [RSW-1:0] rsum_d [KSIZE];

	assign ready_out = !out_valid || !out_stall;
	assign ready_s2  = !valid_s2 || ready_out;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;

	always_comb begin
		logic signed [PW-1:0] px, cf;
		for (int r = 0; r < KSIZE; r++) begin
			for (int c = 0; c < KSIZE; c++) begin
				px = PW'($signed({1'b0, win[r][c]}));
				cf = PW'($signed(cfg.kernel[r][FIELD_BITS*c +: COEF_BITS]));
				prod_d[r][c] = px * cf;
			end
		end
	end

	always_comb begin
		for (int r = 0; r < KSIZE; r++) begin
			rsum_d[r] = '0;
			for (int c = 0; c < KSIZE; c++) begin
				rsum_d[r] = rsum_d[r] + RSW'(prod_s1[r][c]);
			end
		end
	end

	// final sum, round half up, shift, bias, clamp
	logic signed [SW-1:0]  total;
	logic [FRAC_BITS-1:0]  frac_eff;
	logic signed [TW-1:0]  half, rounded, biased;
	logic [PIX_BITS-1:0]   pix_d;

	always_comb begin
		total = '0;
		for (int r = 0; r < KSIZE; r++) begin
			total = total + SW'(rsum_s2[r]);
		end
		frac_eff = (cfg.frac > FRAC_BITS'(MAX_FRAC)) ? FRAC_BITS'(MAX_FRAC) : cfg.frac;
		if (frac_eff == '0) begin
			half = '0;
		end else begin
			half = TW'(1) << (frac_eff - FRAC_BITS'(1));
		end
		rounded = (TW'(total) + half) >>> frac_eff;
		biased  = rounded + TW'(cfg.bias);
		if (biased < 0) begin
			pix_d = '0;
		end else if (biased > TW'(PIX_MAX)) begin
			pix_d = PIX_BITS'(PIX_MAX);
		end else begin
			pix_d = biased[PIX_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_out) begin
				out_valid <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			prod_s1 <= prod_d;
			row_s1  <= in_row;
			col_s1  <= in_col;
		end
		if (ready_s2 && valid_s1) begin
			rsum_s2 <= rsum_d;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
		end
		if (ready_out && valid_s2) begin
			pixel_out <= pix_d;
			out_row   <= row_s2;
			out_col   <= col_s2;
		end
	end

endmodule

`default_nettype wire

>>> src/conv_5x5_valid_window_core.sv
// Top level of the 5x5 valid-window convolution: config registers, raster counters,
// line store and window; uses conv5_pkg, conv5_line and conv5_mac.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------
//  cfg      | cfg_write                 | cfg_index, cfg_data
//  in       | in_valid / in_stall       | pixel_in, start_of_frame
//  out      | out_valid / out_stall     | pixel_out, out_row, out_col
//
// One pixel per clock while in_stall is low; a result passes stage 1, window and MAC stages.
// Throughput is set by the single line store port pair: one read and one write per cycle.
// arst_n clears counters, window, config and all valid flags; the line store is not cleared.
// A stalled output fills the stage registers behind it before in_stall rises.
`default_nettype none

module conv_5x5_valid_window_core
	import conv5_pkg::*;
#(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int COEF_BITS  = DEF_COEF_BITS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [2:0]                     cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]       cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [PIX_BITS-1:0]            pixel_in,
	input  wire logic                           start_of_frame,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [PIX_BITS-1:0]                 pixel_out,
	output logic [$clog2(MAX_HEIGHT)-1:0]       out_row,
	output logic [$clog2(MAX_WIDTH)-1:0]        out_col
);

	localparam int XW   = $clog2(MAX_WIDTH);
	localparam int RW   = $clog2(MAX_HEIGHT);
	localparam int CMPW = (XW + 2 > IW_BITS) ? XW + 2 : IW_BITS;

	// ---------------- configuration ----------------
	filt_cfg_t            cfg_q;
	logic [IW_BITS-1:0]   width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q   <= '0;
			width_q <= IW_BITS'(RESET_WIDTH);
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_KROW0: cfg_q.kernel[0] <= cfg_data[ROW_BITS-1:0];
				REG_KROW1: cfg_q.kernel[1] <= cfg_data[ROW_BITS-1:0];
				REG_KROW2: cfg_q.kernel[2] <= cfg_data[ROW_BITS-1:0];
				REG_KROW3: cfg_q.kernel[3] <= cfg_data[ROW_BITS-1:0];
				REG_KROW4: cfg_q.kernel[4] <= cfg_data[ROW_BITS-1:0];
				REG_FRAC:  cfg_q.frac      <= cfg_data[FRAC_BITS-1:0];
				REG_BIAS:  cfg_q.bias      <= $signed(cfg_data[BIAS_BITS-1:0]);
				REG_WIDTH: width_q         <= cfg_data[IW_BITS-1:0];
				default:   ;
			endcase
		end
	end

	// ---------------- raster position ----------------
	logic [XW-1:0]   col_q, col_cur, col_nxt;
	logic [RW-1:0]   row_q, row_cur, row_nxt, row_bump, row_cur_bump;
	logic [CMPW-1:0] w_eff, col_inc;
	logic            shrink, wrap, emit;
	logic            in_acc;

	always_comb begin
		if (CMPW'(width_q) < CMPW'(MIN_WIDTH)) begin
			w_eff = CMPW'(MIN_WIDTH);
		end else if (CMPW'(width_q) > CMPW'(MAX_WIDTH)) begin
			w_eff = CMPW'(MAX_WIDTH);
		end else begin
			w_eff = CMPW'(width_q);
		end

		row_bump = (row_q < RW'(MAX_HEIGHT - 1)) ? row_q + RW'(1) : row_q;
		shrink   = CMPW'(col_q) >= w_eff;
		if (start_of_frame) begin
			col_cur = '0;
			row_cur = '0;
		end else if (shrink) begin
			col_cur = '0;
			row_cur = row_bump;
		end else begin
			col_cur = col_q;
			row_cur = row_q;
		end

		row_cur_bump = (row_cur < RW'(MAX_HEIGHT - 1)) ? row_cur + RW'(1) : row_cur;
		col_inc      = CMPW'(col_cur) + CMPW'(1);
		wrap         = col_inc >= w_eff;
		col_nxt      = wrap ? '0 : col_inc[XW-1:0];
		row_nxt      = wrap ? row_cur_bump : row_cur;
		emit         = (row_cur >= RW'(WIN_EDGE)) && (col_cur >= XW'(WIN_EDGE));
	end

	// ---------------- stage 1: pixel + line store word ----------------
	logic                  valid_s1, emit_s1;
	logic [PIX_BITS-1:0]   pix_s1;
	logic [XW-1:0]         col_s1;
	logic [RW-1:0]         orow_s1;
	logic [XW-1:0]         ocol_s1;
	logic                  ready_s1, ready_s2, adv_s1;
	logic [LINE_BITS-1:0]  line_rd;

	assign ready_s1 = !valid_s1 || ready_s2;
	assign adv_s1   = valid_s1 && ready_s2;
	assign in_stall = !ready_s1;
	assign in_acc   = in_valid && ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (in_acc) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= pixel_in;
			col_s1  <= col_cur;
			emit_s1 <= emit;
			orow_s1 <= row_cur - RW'(WIN_EDGE);
			ocol_s1 <= col_cur - XW'(WIN_EDGE);
		end
	end

	conv5_line #(
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk     (clk),
		.rd_en   (in_acc),
		.rd_addr (col_cur),
		.rd_data (line_rd),
		.wr_en   (adv_s1),
		.wr_addr (col_s1),
		.wr_data ({pix_s1, line_rd[LINE_BITS-1:PIX_BITS]})
	);

	// ---------------- stage 2: sliding window ----------------
	window_t                           window_q;
	logic [KSIZE-1:0][PIX_BITS-1:0]    new_col;
	logic                              valid_s2, mac_ready;
	logic [RW-1:0]                     orow_s2;
	logic [XW-1:0]                     ocol_s2;

	assign ready_s2 = !valid_s2 || mac_ready;

	always_comb begin
		for (int r = 0; r < KSIZE - 1; r++) begin
			new_col[r] = line_rd[PIX_BITS*r +: PIX_BITS];
		end
		new_col[KSIZE-1] = pix_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s2) begin
				valid_s2 <= adv_s1 && emit_s1;
			end
			if (adv_s1) begin
				for (int r = 0; r < KSIZE; r++) begin
					for (int c = 0; c < KSIZE - 1; c++) begin
						window_q[r][c] <= window_q[r][c+1];
					end
					window_q[r][KSIZE-1] <= new_col[r];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
		end
	end

	conv5_mac #(
		.COEF_BITS (COEF_BITS),
		.RW        (RW),
		.XW        (XW)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (valid_s2),
		.in_ready  (mac_ready),
		.win       (window_q),
		.in_row    (orow_s2),
		.in_col    (ocol_s2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pixel_out (pixel_out),
		.out_row   (out_row),
		.out_col   (out_col)
	);

endmodule

`default_nettype wire

>>> bench/conv_5x5_valid_window_core_test.sv
// Self-checking bench for conv_5x5_valid_window_core: raster pixel streams under random
// idling and back-pressure, with every windowed result checked by a built-in predictor.
// Depends on conv5_pkg and the core RTL only.
module conv_5x5_valid_window_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import conv5_pkg::*;

	localparam int ROW_W = $clog2(DEF_MAX_HEIGHT);
	localparam int COL_W = $clog2(DEF_MAX_WIDTH);
	localparam int LINE_DEPTH = DEF_MAX_WIDTH;
	localparam int HEIGHT_LIMIT = DEF_MAX_HEIGHT;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES = 300;
	localparam int FINAL_WAIT = 100000;
	localparam int PHASE_ITEMS = 125;

	typedef enum {KERN_WILD, KERN_SMALL, KERN_BLUR} kern_style_t;

	typedef struct {
		logic [PIX_BITS-1:0] pix;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} conv_out_t;

	class conv_scoreboard;
		logic [ROW_BITS-1:0] krow [KSIZE];
		logic [FRAC_BITS-1:0] frac;
		logic signed [BIAS_BITS-1:0] bias;
		logic [IW_BITS-1:0] width;
		logic [LINE_BITS-1:0] line_mem [LINE_DEPTH];
		logic [PIX_BITS-1:0] win [KSIZE][KSIZE];
		int unsigned col_cnt;
		int unsigned row_cnt;
		int unsigned col_fills [LINE_DEPTH];
		conv_out_t pending_q [$];
		int errors;

		function new();
			foreach (krow[r])
				krow[r] = '0;
			frac = '0;
			bias = '0;
			width = IW_BITS'(RESET_WIDTH);
			foreach (line_mem[i])
				line_mem[i] = '0;
			foreach (col_fills[i])
				col_fills[i] = 0;
			foreach (win[r, c])
				win[r][c] = '0;
			col_cnt = 0;
			row_cnt = 0;
			errors = 0;
		endfunction

		function int unsigned line_width(logic [IW_BITS-1:0] w);
			if (w < MIN_WIDTH)
				return MIN_WIDTH;
			if (w > LINE_DEPTH)
				return LINE_DEPTH;
			return w;
		endfunction

		// every word below w holds four rows of real pixels
		function bit lines_full(int unsigned w);
			for (int unsigned i = 0; i < w; i++)
				if (col_fills[i] < KSIZE - 1)
					return 1'b0;
			return 1'b1;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
			REG_FRAC: frac = data[FRAC_BITS-1:0];
			REG_BIAS: bias = data[BIAS_BITS-1:0];
			REG_WIDTH: width = data[IW_BITS-1:0];
			default: krow[idx] = data;
			endcase
		endfunction

		function logic [PIX_BITS-1:0] filter();
			longint acc;
			longint val;
			int fs;
			logic signed [FIELD_BITS-1:0] coef;
			acc = 0;
			for (int r = 0; r < KSIZE; r++)
				for (int c = 0; c < KSIZE; c++) begin
					coef = krow[r][c*FIELD_BITS +: FIELD_BITS];
					acc += longint'(coef) * longint'(win[r][c]);
				end
			fs = (frac > MAX_FRAC) ? MAX_FRAC : frac;
			// round half up: arithmetic shift floors negative sums too
			val = (fs > 0) ? ((acc + (longint'(1) << (fs - 1))) >>> fs) : acc;
			val += longint'(bias);
			if (val < 0)
				return '0;
			if (val > PIX_MAX)
				return PIX_BITS'(PIX_MAX);
			return val[PIX_BITS-1:0];
		endfunction

		function void note_pixel(logic [PIX_BITS-1:0] pix, logic sof);
			int unsigned w;
			int unsigned addr;
			logic [LINE_BITS-1:0] word;
			logic [PIX_BITS-1:0] column [KSIZE];
			conv_out_t res;
			w = line_width(width);
			if (sof) begin
				col_cnt = 0;
				row_cnt = 0;
			end else if (col_cnt >= w) begin
				// width shrunk under a partly done row
				col_cnt = 0;
				if (row_cnt < HEIGHT_LIMIT - 1)
					row_cnt++;
			end
			addr = col_cnt % LINE_DEPTH;
			word = line_mem[addr];
			for (int r = 0; r < KSIZE - 1; r++)
				column[r] = word[r*PIX_BITS +: PIX_BITS];
			column[KSIZE-1] = pix;
			line_mem[addr] = {pix, word[LINE_BITS-1:PIX_BITS]};
			if (col_fills[addr] < KSIZE - 1)
				col_fills[addr]++;
			for (int r = 0; r < KSIZE; r++) begin
				for (int c = 0; c < KSIZE - 1; c++)
					win[r][c] = win[r][c+1];
				win[r][KSIZE-1] = column[r];
			end
			if (row_cnt >= WIN_EDGE && col_cnt >= WIN_EDGE) begin
				res.pix = filter();
				res.row = ROW_W'(row_cnt - WIN_EDGE);
				res.col = COL_W'(col_cnt - WIN_EDGE);
				pending_q.push_back(res);
			end
			col_cnt++;
			if (col_cnt >= w) begin
				col_cnt = 0;
				if (row_cnt < HEIGHT_LIMIT - 1)
					row_cnt++;
			end
		endfunction

		function void mismatch(string field, logic [ROW_W-1:0] want, logic [ROW_W-1:0] got);
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
		endfunction

		function void check_result(logic [PIX_BITS-1:0] pix, logic [ROW_W-1:0] row,
				logic [COL_W-1:0] col);
			conv_out_t want;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got pixel %0d at %0d,%0d",
					$time, pix, row, col);
				return;
			end
			want = pending_q.pop_front();
			if (pix !== want.pix)
				mismatch("pixel_out", want.pix, pix);
			if (row !== want.row)
				mismatch("out_row", want.row, row);
			if (col !== want.col)
				mismatch("out_col", want.col, col);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIX_BITS-1:0] pixel_in = '0;
	logic start_of_frame = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_BITS-1:0] pixel_out;
	logic [ROW_W-1:0] out_row;
	logic [COL_W-1:0] out_col;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_req = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;

	logic [ROW_BITS-1:0] cur_krow [KSIZE];
	logic [FRAC_BITS-1:0] cur_frac;
	logic [BIAS_BITS-1:0] cur_bias;
	logic [IW_BITS-1:0] cur_width;

	conv_scoreboard sb = new();

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	conv_5x5_valid_window_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel_in(pixel_in),
		.start_of_frame(start_of_frame),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.pixel_out(pixel_out),
		.out_row(out_row),
		.out_col(out_col)
	);

	// result side: check each transaction, then pick the next stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result(pixel_out, out_row, out_col);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else
				out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic send_pixel(input logic [PIX_BITS-1:0] pix, input logic sof);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel_in <= pix;
		start_of_frame <= sof;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_pixel(pix, sof);
	endtask

	task automatic await_results;
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending_q.size() != 0);
	endtask

	task automatic settle;
		await_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting;
		cfg_reg_t idx;
		logic [CFG_DATA_BITS-1:0] data;
		idx = idx.first();
		do begin
			data = '0;
			case (idx)
			REG_FRAC: data[FRAC_BITS-1:0] = cur_frac;
			REG_BIAS: data[BIAS_BITS-1:0] = cur_bias;
			REG_WIDTH: data[IW_BITS-1:0] = cur_width;
			default: data = cur_krow[idx];
			endcase
			cfg_write <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			@(posedge clk);
			sb.write_reg(idx, data);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_write <= 1'b0;
	endtask

	function automatic logic [ROW_BITS-1:0] make_row(kern_style_t style);
		logic [ROW_BITS-1:0] row;
		logic [FIELD_BITS-1:0] f;
		for (int c = 0; c < KSIZE; c++) begin
			case (style)
			KERN_WILD: f = FIELD_BITS'($urandom);
			KERN_SMALL: f = FIELD_BITS'($urandom_range(32) - 16);
			default: f = FIELD_BITS'($urandom_range(63));
			endcase
			row[c*FIELD_BITS +: FIELD_BITS] = f;
		end
		return row;
	endfunction

	function automatic logic [PIX_BITS-1:0] rand_pixel();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return PIX_BITS'(PIX_MAX);
		return PIX_BITS'($urandom);
	endfunction

	task automatic random_setting;
		kern_style_t style;
		int unsigned pick;
		style = kern_style_t'($urandom_range(2));
		foreach (cur_krow[r])
			cur_krow[r] = make_row(style);
		case (style)
		KERN_WILD: cur_frac = FRAC_BITS'($urandom);
		KERN_SMALL: cur_frac = FRAC_BITS'($urandom_range(4));
		default: cur_frac = FRAC_BITS'($urandom_range(6, 11));
		endcase
		cur_bias = $urandom_range(1) ? BIAS_BITS'($urandom) :
			BIAS_BITS'($urandom_range(31) - 16);
		pick = $urandom_range(99);
		if (pick < 10)
			cur_width = IW_BITS'($urandom_range(MIN_WIDTH - 1));
		else if (pick < 85)
			cur_width = IW_BITS'($urandom_range(MIN_WIDTH, 24));
		else
			cur_width = IW_BITS'($urandom_range(25, 64));
	endtask

	// frames of 5..8 rows with random content; a few drop their start mark, a few
	// restart mid-row
	task automatic run_random_phase(input int n_items, input int hold_at, input int pause_at);
		int unsigned w;
		int frame_left;
		bit force_sof;
		logic sof;
		settle();
		random_setting();
		apply_setting();
		w = sb.line_width(cur_width);
		// carrying on without a mark is safe only over words filled four rows deep
		force_sof = !(sb.lines_full(w) && $urandom_range(2) == 0);
		frame_left = force_sof ? 0 : w * $urandom_range(2, 5);
		for (int i = 0; i < n_items; i++) begin
			if (i == hold_at)
				hold_req <= 1'b1;
			if (i == pause_at)
				await_results();
			if (frame_left <= 0) begin
				sof = force_sof || ($urandom_range(4) != 0);
				force_sof = 1'b0;
				frame_left = w * $urandom_range(5, 8);
			end else
				sof = ($urandom_range(99) < 2);
			frame_left--;
			send_pixel(rand_pixel(), sof);
		end
	endtask

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		send_idle_pct = 26;
		recv_idle_pct = 80;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// saturation high: largest coefficients, full pixels, largest bias
		foreach (cur_krow[r])
			cur_krow[r] = {KSIZE{12'h7FF}};
		cur_frac = '0;
		cur_bias = 9'h0FF;
		cur_width = MIN_WIDTH;
		apply_setting();
		for (int i = 0; i < KSIZE * KSIZE; i++)
			send_pixel(PIX_BITS'(PIX_MAX), i == 0);
		settle();

		// saturation low; frac beyond 12 clamps, width below 5 clamps
		foreach (cur_krow[r])
			cur_krow[r] = {KSIZE{12'h800}};
		cur_frac = '1;
		cur_bias = 9'h100;
		cur_width = '0;
		apply_setting();
		for (int i = 0; i < KSIZE * KSIZE; i++)
			send_pixel(PIX_BITS'(PIX_MAX), i == 0);
		settle();

		// rounding of a negative half: only the center coefficient, -1 with one fraction bit
		foreach (cur_krow[r])
			cur_krow[r] = '0;
		cur_krow[2][2*FIELD_BITS +: FIELD_BITS] = 12'hFFF;
		cur_frac = 1;
		cur_bias = 10;
		cur_width = MIN_WIDTH;
		apply_setting();
		for (int i = 0; i < KSIZE * KSIZE; i++)
			send_pixel((i == 12) ? 8'd5 : 8'd0, i == 0);
		settle();

		// width shrunk while a row is half done, then carry on with no start mark
		foreach (cur_krow[r])
			cur_krow[r] = make_row(KERN_SMALL);
		cur_frac = 2;
		cur_bias = 9'h1F0;
		cur_width = 40;
		apply_setting();
		for (int i = 0; i < 40 * 5 + 25; i++)
			send_pixel(rand_pixel(), i == 0);
		settle();
		cur_width = 12;
		apply_setting();
		for (int i = 0; i < 12 * 3; i++)
			send_pixel(rand_pixel(), 1'b0);

		for (int p = 0; p < 4; p++)
			run_random_phase(PHASE_ITEMS, (p == 1) ? 80 : -1, (p == 2) ? 70 : -1);

		send_idle_pct = 80;
		recv_idle_pct = 26;
		for (int p = 0; p < 4; p++)
			run_random_phase(PHASE_ITEMS, -1, -1);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int p = 0; p < 4; p++)
			run_random_phase(PHASE_ITEMS, -1, -1);

		in_valid <= 1'b0;
		for (int i = 0; i < FINAL_WAIT && sb.pending_q.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.pending_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.pending_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> sim.f
src/conv5_pkg.sv
src/conv5_line.sv
src/conv5_mac.sv
src/conv_5x5_valid_window_core.sv
bench/conv_5x5_valid_window_core_test.sv
